/* rtl/mesh_signed_volume_accumulator_assert.svh */
// Assertion macros for the volume accumulator checker.
`ifndef MESH_SIGNED_VOLUME_ACCUMULATOR_ASSERT_SVH
`define MESH_SIGNED_VOLUME_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define MSVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("volume accumulator check failed");

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define MSVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("volume accumulator check failed");

`endif

/* rtl/msva_pkg.sv */
// Types, constants and the control store of the mesh volume accumulator.
package msva_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATRIX_ROW0 = 2'd0;
  localparam logic [1:0] REG_MATRIX_ROW1 = 2'd1;
  localparam logic [1:0] REG_MATRIX_ROW2 = 2'd2;

  // Identity matrix in Q3.12.
  localparam logic [47:0] MATRIX_ROW0_RESET = 48'h0000_0000_1000;
  localparam logic [47:0] MATRIX_ROW1_RESET = 48'h0000_1000_0000;
  localparam logic [47:0] MATRIX_ROW2_RESET = 48'h1000_0000_0000;

  // Division by six, one byte a step: q = (v * 683) >> 12 is exact for v < 1536.
  localparam int unsigned DIVISOR     = 6;
  localparam int unsigned DIV6_RECIP  = 683;
  localparam int unsigned DIV6_SHIFT  = 12;
  localparam logic [2:0]  DIV_LAST    = 3'd7;

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  localparam logic [4:0] STEP_IDLE = 5'd0;

  typedef struct packed {
    logic              start_new_mesh;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [47:0]        normal;
  } tri_t;

  typedef enum logic [3:0] {
    X_N0, X_N1, X_N2, X_B0, X_B1, X_B2,
    X_NT0, X_NT1, X_NT2, X_M0, X_M1, X_M2
  } xsel_t;

  typedef enum logic [4:0] {
    Y_M00, Y_M01, Y_M02, Y_M10, Y_M11, Y_M12, Y_M20, Y_M21, Y_M22,
    Y_C0, Y_C1, Y_C2, Y_S0, Y_S1, Y_S2, Y_A0, Y_A1, Y_A2
  } ysel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_NT0, DST_NT1, DST_NT2, DST_M0, DST_M1, DST_M2, DST_DOT, DST_MAG
  } dst_t;

  typedef enum logic [2:0] {OP_NONE, OP_ACCUM, OP_DIV_INIT, OP_DIV_STEP, OP_EMIT} op_t;

  typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_LOOP, SEQ_EMIT} seq_t;

  typedef struct packed {
    xsel_t   xsel;
    ysel_t   ysel;
    acc_op_t acc;
    dst_t    dst;
    op_t     op;
    seq_t    seq;
  } ucode_t;

  // The product of a step is registered, so the accumulate field of each word acts on the
  // previous multiply and the store field saves the accumulator as the previous word left it.
  function automatic ucode_t ucode_rom(input logic [4:0] addr);
    ucode_t w;
    case (addr)
      5'd0:  w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_NONE,     SEQ_WAIT_IN};
      5'd1:  w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd2:  w = '{X_N1,  Y_M10, ACC_LOAD, DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd3:  w = '{X_N2,  Y_M20, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd4:  w = '{X_N0,  Y_M01, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd5:  w = '{X_N1,  Y_M11, ACC_LOAD, DST_NT0,  OP_NONE,     SEQ_NEXT};
      5'd6:  w = '{X_N2,  Y_M21, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd7:  w = '{X_N0,  Y_M02, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd8:  w = '{X_N1,  Y_M12, ACC_LOAD, DST_NT1,  OP_NONE,     SEQ_NEXT};
      5'd9:  w = '{X_N2,  Y_M22, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd10: w = '{X_B1,  Y_C2,  ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd11: w = '{X_B2,  Y_C1,  ACC_LOAD, DST_NT2,  OP_NONE,     SEQ_NEXT};
      5'd12: w = '{X_B0,  Y_C2,  ACC_SUB,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd13: w = '{X_B2,  Y_C0,  ACC_LOAD, DST_M0,   OP_NONE,     SEQ_NEXT};
      5'd14: w = '{X_B0,  Y_C1,  ACC_SUB,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd15: w = '{X_B1,  Y_C0,  ACC_LOAD, DST_M1,   OP_NONE,     SEQ_NEXT};
      5'd16: w = '{X_NT0, Y_S0,  ACC_SUB,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd17: w = '{X_NT1, Y_S1,  ACC_LOAD, DST_M2,   OP_NONE,     SEQ_NEXT};
      5'd18: w = '{X_NT2, Y_S2,  ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd19: w = '{X_M0,  Y_A0,  ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd20: w = '{X_M1,  Y_A1,  ACC_LOAD, DST_DOT,  OP_NONE,     SEQ_NEXT};
      5'd21: w = '{X_M2,  Y_A2,  ACC_SUB,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd22: w = '{X_N0,  Y_M00, ACC_ADD,  DST_NONE, OP_NONE,     SEQ_NEXT};
      5'd23: w = '{X_N0,  Y_M00, ACC_HOLD, DST_MAG,  OP_NONE,     SEQ_NEXT};
      5'd24: w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_ACCUM,    SEQ_NEXT};
      5'd25: w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_DIV_INIT, SEQ_NEXT};
      5'd26: w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_DIV_STEP, SEQ_LOOP};
      5'd27: w = '{X_N0,  Y_M00, ACC_HOLD, DST_NONE, OP_EMIT,     SEQ_EMIT};
      default: w = '{X_N0, Y_M00, ACC_HOLD, DST_NONE, OP_NONE,    SEQ_WAIT_IN};
    endcase
    return w;
  endfunction

endpackage

/* rtl/msva_datapath.sv */
// Shared multiplier, accumulator and operand registers that form det and dot.
module msva_datapath (
  input  logic                 clk,
  input  logic                 load,
  input  msva_pkg::tri_t       tri_in,
  input  logic [2:0][47:0]     matrix,
  input  msva_pkg::ucode_t     ctl,
  output logic [48:0]          mag,
  output logic                 dot_neg
);
  import msva_pkg::*;

  logic signed [15:0] va [3];
  logic signed [15:0] vb [3];
  logic signed [15:0] vc [3];
  logic signed [15:0] vn [3];
  logic signed [17:0] vs [3];
  logic signed [32:0] nt [3];
  logic signed [32:0] minor [3];
  logic signed [32:0] x_op;
  logic signed [17:0] y_op;
  logic signed [50:0] prod;
  logic signed [51:0] acc;
  logic signed [51:0] acc_abs;

  always_comb begin
    case (ctl.xsel)
      X_N0:    x_op = 33'(vn[0]);
      X_N1:    x_op = 33'(vn[1]);
      X_N2:    x_op = 33'(vn[2]);
      X_B0:    x_op = 33'(vb[0]);
      X_B1:    x_op = 33'(vb[1]);
      X_B2:    x_op = 33'(vb[2]);
      X_NT0:   x_op = nt[0];
      X_NT1:   x_op = nt[1];
      X_NT2:   x_op = nt[2];
      X_M0:    x_op = minor[0];
      X_M1:    x_op = minor[1];
      X_M2:    x_op = minor[2];
      default: x_op = '0;
    endcase
  end

  // Matrix entry Mij is lane j of row i.
  always_comb begin
    case (ctl.ysel)
      Y_M00:   y_op = 18'(signed'(matrix[0][15:0]));
      Y_M01:   y_op = 18'(signed'(matrix[0][31:16]));
      Y_M02:   y_op = 18'(signed'(matrix[0][47:32]));
      Y_M10:   y_op = 18'(signed'(matrix[1][15:0]));
      Y_M11:   y_op = 18'(signed'(matrix[1][31:16]));
      Y_M12:   y_op = 18'(signed'(matrix[1][47:32]));
      Y_M20:   y_op = 18'(signed'(matrix[2][15:0]));
      Y_M21:   y_op = 18'(signed'(matrix[2][31:16]));
      Y_M22:   y_op = 18'(signed'(matrix[2][47:32]));
      Y_C0:    y_op = 18'(vc[0]);
      Y_C1:    y_op = 18'(vc[1]);
      Y_C2:    y_op = 18'(vc[2]);
      Y_S0:    y_op = vs[0];
      Y_S1:    y_op = vs[1];
      Y_S2:    y_op = vs[2];
      Y_A0:    y_op = 18'(va[0]);
      Y_A1:    y_op = 18'(va[1]);
      Y_A2:    y_op = 18'(va[2]);
      default: y_op = '0;
    endcase
  end

  assign acc_abs = acc[51] ? -acc : acc;

  always_ff @(posedge clk) begin
    if (load) begin
      va[0] <= tri_in.ax;
      va[1] <= tri_in.ay;
      va[2] <= tri_in.az;
      vb[0] <= tri_in.bx;
      vb[1] <= tri_in.by;
      vb[2] <= tri_in.bz;
      vc[0] <= tri_in.cx;
      vc[1] <= tri_in.cy;
      vc[2] <= tri_in.cz;
      vn[0] <= signed'(tri_in.normal[15:0]);
      vn[1] <= signed'(tri_in.normal[31:16]);
      vn[2] <= signed'(tri_in.normal[47:32]);
      vs[0] <= 18'(tri_in.ax) + 18'(tri_in.bx) + 18'(tri_in.cx);
      vs[1] <= 18'(tri_in.ay) + 18'(tri_in.by) + 18'(tri_in.cy);
      vs[2] <= 18'(tri_in.az) + 18'(tri_in.bz) + 18'(tri_in.cz);
    end

    prod <= x_op * y_op;

    case (ctl.acc)
      ACC_LOAD: acc <= 52'(prod);
      ACC_ADD:  acc <= acc + 52'(prod);
      ACC_SUB:  acc <= acc - 52'(prod);
      default:  acc <= acc;
    endcase

    case (ctl.dst)
      DST_NT0: nt[0]    <= acc[32:0];
      DST_NT1: nt[1]    <= acc[32:0];
      DST_NT2: nt[2]    <= acc[32:0];
      DST_M0:  minor[0] <= acc[32:0];
      DST_M1:  minor[1] <= acc[32:0];
      DST_M2:  minor[2] <= acc[32:0];
      DST_DOT: dot_neg  <= acc[51];
      DST_MAG: mag      <= acc_abs[48:0];
      default: ;
    endcase
  end

endmodule

/* rtl/mesh_signed_volume_accumulator.sv */
// Takes one item at a time: in_ready is high only while the sequencer waits for input.
// A control store of 28 words steps one shared 33x18 multiplier through 21 products,
// then a byte-serial divide by six forms the quotient a byte at a time.
// The next item is taken once the result is loaded into the output register.
// Synchronous reset clears the sum, the overflow flag, the sequencer and the output valid,
// and loads the identity matrix.
module mesh_signed_volume_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_new_mesh,
  input  logic signed [15:0] vertex_a_x,
  input  logic signed [15:0] vertex_a_y,
  input  logic signed [15:0] vertex_a_z,
  input  logic signed [15:0] vertex_b_x,
  input  logic signed [15:0] vertex_b_y,
  input  logic signed [15:0] vertex_b_z,
  input  logic signed [15:0] vertex_c_x,
  input  logic signed [15:0] vertex_c_y,
  input  logic signed [15:0] vertex_c_z,
  input  logic [47:0]        face_normal,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [61:0] mesh_volume,
  output logic               overflowed
);
  import msva_pkg::*;

  logic [4:0]         step;
  ucode_t             ctl;
  logic [2:0][47:0]   matrix;
  tri_t               tri_in;
  logic               in_accept;
  logic               out_free;
  logic [48:0]        mag;
  logic               dot_neg;
  logic signed [63:0] sum;
  logic signed [63:0] sum_next;
  logic signed [64:0] sum_ext;
  logic               sum_ovf;
  logic               sat;
  logic [63:0]        dvd;
  logic [63:0]        quot;
  logic               q_neg;
  logic [2:0]         rem;
  logic [2:0]         div_cnt;
  logic [10:0]        div_v;
  logic [20:0]        div_prod;
  logic [7:0]         div_q;
  logic [10:0]        div_r;

  assign ctl       = ucode_rom(step);
  assign in_ready  = (ctl.seq == SEQ_WAIT_IN);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign tri_in = '{start_new_mesh, vertex_a_x, vertex_a_y, vertex_a_z,
                    vertex_b_x, vertex_b_y, vertex_b_z,
                    vertex_c_x, vertex_c_y, vertex_c_z, face_normal};

  msva_datapath u_datapath (
    .clk     (clk),
    .load    (in_accept),
    .tri_in  (tri_in),
    .matrix  (matrix),
    .ctl     (ctl),
    .mag     (mag),
    .dot_neg (dot_neg)
  );

  // Saturating update of the running sum with one guard bit.
  always_comb begin
    if (dot_neg) begin
      sum_ext = 65'(sum) - 65'(mag);
    end else begin
      sum_ext = 65'(sum) + 65'(mag);
    end
    sum_ovf = sum_ext[64] != sum_ext[63];
    if (sum_ovf) begin
      sum_next = dot_neg ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_ext[63:0];
    end
  end

  // One quotient byte per step; the partial remainder stays below six.
  always_comb begin
    div_v    = {rem, dvd[63:56]};
    div_prod = 21'(div_v) * 21'(DIV6_RECIP);
    div_q    = div_prod[DIV6_SHIFT +: 8];
    div_r    = div_v - 11'(div_q) * 11'(DIVISOR);
  end

  assign quot = q_neg ? -dvd : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
      sat       <= 1'b0;
      matrix[0] <= MATRIX_ROW0_RESET;
      matrix[1] <= MATRIX_ROW1_RESET;
      matrix[2] <= MATRIX_ROW2_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MATRIX_ROW0: matrix[0] <= cfg_data;
          REG_MATRIX_ROW1: matrix[1] <= cfg_data;
          REG_MATRIX_ROW2: matrix[2] <= cfg_data;
          default: ;
        endcase
      end

      case (ctl.seq)
        SEQ_WAIT_IN: begin
          if (in_accept) begin
            step <= step + 5'd1;
          end
        end
        SEQ_LOOP: begin
          if (div_cnt == DIV_LAST) begin
            step <= step + 5'd1;
          end
        end
        SEQ_EMIT: begin
          if (out_free) begin
            step <= STEP_IDLE;
          end
        end
        default: step <= step + 5'd1;
      endcase

      if (in_accept && start_new_mesh) begin
        sum <= '0;
        sat <= 1'b0;
      end else if (ctl.op == OP_ACCUM) begin
        sum <= sum_next;
        sat <= sat | sum_ovf;
      end

      if (ctl.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_DIV_INIT: begin
        dvd     <= sum[63] ? 64'(-sum) : 64'(sum);
        q_neg   <= sum[63];
        rem     <= '0;
        div_cnt <= '0;
      end
      OP_DIV_STEP: begin
        dvd     <= {dvd[55:0], div_q};
        rem     <= div_r[2:0];
        div_cnt <= div_cnt + 3'd1;
      end
      OP_EMIT: begin
        if (out_free) begin
          mesh_volume <= signed'(quot[61:0]);
          overflowed  <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/msva_checker.sv */
// Port-level checker for the mesh volume accumulator, bound to the top level.
`include "mesh_signed_volume_accumulator_assert.svh"

module msva_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [61:0] mesh_volume,
  input logic               overflowed
);

  // Items taken in but whose result has not yet been taken out.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  `MSVA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `MSVA_ASSERT_IMP(a_pending_bound, 1'b1, pending != 2'd3)
  `MSVA_ASSERT_IMP(a_result_has_item, out_valid, pending != 2'd0)
  `MSVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mesh_volume) && $stable(overflowed))

endmodule

bind mesh_signed_volume_accumulator msva_checker u_msva_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mesh_volume (mesh_volume),
  .overflowed  (overflowed)
);

/* test/tb_top.sv */
// Self-checking testbench for the mesh signed volume accumulator.
`timescale 1ns / 100ps

module tb_top;
  import msva_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic signed [15:0] VUNIT = 16'sd256;
  localparam logic signed [15:0] VLO   = 16'sh8000;
  localparam logic signed [15:0] VHI   = 16'sh7FFF;

  localparam logic [47:0] N_ZERO = 48'h0000_0000_0000;
  localparam logic [47:0] N_POS  = 48'h4000_4000_4000;
  localparam logic [47:0] N_NEG  = 48'hC000_C000_C000;
  localparam logic [47:0] N_MIN  = 48'h8000_8000_8000;
  localparam logic [47:0] N_MAX  = 48'h7FFF_7FFF_7FFF;
  localparam logic [47:0] N_XNEG = 48'h0000_0000_C000;
  localparam logic [47:0] N_XPOS = 48'h0000_0000_4000;

  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED   = 100;

  typedef struct packed {
    logic signed [61:0] volume;
    logic               ovf;
  } volume_result_t;

  typedef struct packed {
    tri_t           item;
    logic           typed;
    volume_result_t want;
  } directed_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               start_new_mesh;
  logic signed [15:0] vertex_a_x;
  logic signed [15:0] vertex_a_y;
  logic signed [15:0] vertex_a_z;
  logic signed [15:0] vertex_b_x;
  logic signed [15:0] vertex_b_y;
  logic signed [15:0] vertex_b_z;
  logic signed [15:0] vertex_c_x;
  logic signed [15:0] vertex_c_y;
  logic signed [15:0] vertex_c_z;
  logic [47:0]        face_normal;
  logic               out_valid;
  logic               out_ready;
  logic signed [61:0] mesh_volume;
  logic               overflowed;

  // Predictor state: matrix rows, running determinant sum and sticky clamp flag.
  logic [47:0]    mat_row [3];
  longint         det_sum;
  logic           sum_sat;

  volume_result_t pending_volumes[$];
  directed_row_t  directed_rows[$];
  int             mismatch_count = 0;
  int             results_seen = 0;
  int             in_idle_max = 14;
  int             out_stall_max = 14;

  mesh_signed_volume_accumulator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_new_mesh (start_new_mesh),
    .vertex_a_x     (vertex_a_x),
    .vertex_a_y     (vertex_a_y),
    .vertex_a_z     (vertex_a_z),
    .vertex_b_x     (vertex_b_x),
    .vertex_b_y     (vertex_b_y),
    .vertex_b_z     (vertex_b_z),
    .vertex_c_x     (vertex_c_x),
    .vertex_c_y     (vertex_c_y),
    .vertex_c_z     (vertex_c_z),
    .face_normal    (face_normal),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mesh_volume    (mesh_volume),
    .overflowed     (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL mesh_signed_volume_accumulator");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    end
  endtask

  function automatic longint lane_of(input logic [47:0] packed_word, input int j);
    logic signed [15:0] v;
    v = packed_word[16*j +: 16];
    return longint'(v);
  endfunction

  // Applies one triangle to the predictor state and returns the expected output.
  task automatic accumulate_triangle(input tri_t t, output volume_result_t r);
    longint a [3];
    longint b [3];
    longint c [3];
    longint nrm [3];
    longint nt [3];
    longint dot;
    longint det;
    longint mag;
    logic signed [63:0] quo;
    if (t.start_new_mesh) begin
      det_sum = 0;
      sum_sat = 1'b0;
    end
    a[0] = $signed(t.ax); a[1] = $signed(t.ay); a[2] = $signed(t.az);
    b[0] = $signed(t.bx); b[1] = $signed(t.by); b[2] = $signed(t.bz);
    c[0] = $signed(t.cx); c[1] = $signed(t.cy); c[2] = $signed(t.cz);
    for (int i = 0; i < 3; i++) begin
      nrm[i] = lane_of(t.normal, i);
    end
    // Row-vector transform: each output lane sums one column of the matrix.
    for (int j = 0; j < 3; j++) begin
      nt[j] = 0;
      for (int i = 0; i < 3; i++) begin
        nt[j] += nrm[i] * lane_of(mat_row[i], j);
      end
    end
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      dot += nt[i] * (a[i] + b[i] + c[i]);
    end
    det = a[0] * (b[1] * c[2] - b[2] * c[1])
        - a[1] * (b[0] * c[2] - b[2] * c[0])
        + a[2] * (b[0] * c[1] - b[1] * c[0]);
    mag = (det < 0) ? -det : det;
    if (dot >= 0) begin
      if (det_sum > longint'(SUM_MAX) - mag) begin
        det_sum = longint'(SUM_MAX);
        sum_sat = 1'b1;
      end else begin
        det_sum += mag;
      end
    end else begin
      if (det_sum < longint'(SUM_MIN) + mag) begin
        det_sum = longint'(SUM_MIN);
        sum_sat = 1'b1;
      end else begin
        det_sum -= mag;
      end
    end
    quo = det_sum / longint'(DIVISOR);
    r.volume = quo[61:0];
    r.ovf = sum_sat;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_MATRIX_ROW0: mat_row[0] = value;
      REG_MATRIX_ROW1: mat_row[1] = value;
      REG_MATRIX_ROW2: mat_row[2] = value;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input logic [47:0] r0, input logic [47:0] r1,
                             input logic [47:0] r2);
    write_reg(REG_MATRIX_ROW0, r0);
    write_reg(REG_MATRIX_ROW1, r1);
    write_reg(REG_MATRIX_ROW2, r2);
  endtask

  // Offers one triangle and logs its expected volume once it is taken.
  task automatic send_triangle(input tri_t t, input logic use_typed,
                               input volume_result_t typed_want);
    int gap;
    volume_result_t predicted;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_new_mesh <= t.start_new_mesh;
    vertex_a_x <= t.ax;
    vertex_a_y <= t.ay;
    vertex_a_z <= t.az;
    vertex_b_x <= t.bx;
    vertex_b_y <= t.by;
    vertex_b_z <= t.bz;
    vertex_c_x <= t.cx;
    vertex_c_y <= t.cy;
    vertex_c_z <= t.cz;
    face_normal <= t.normal;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    accumulate_triangle(t, predicted);
    pending_volumes.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_volumes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return VLO;
      1: return VHI;
      2, 3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_lane();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_matrix_entry();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hF000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_matrix_row();
    return {rand_matrix_entry(), rand_matrix_entry(), rand_matrix_entry()};
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    t.start_new_mesh = ($urandom_range(0, 15) == 0);
    t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
    t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
    t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
    t.normal = ($urandom_range(0, 15) == 0) ? N_ZERO
                                            : {rand_lane(), rand_lane(), rand_lane()};
    // A repeated vertex makes the triangle flat.
    if ($urandom_range(0, 15) == 0) begin
      t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
    end
    return t;
  endfunction

  task automatic run_random(input int count);
    int mode;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        mode = $urandom_range(0, 3);
        in_idle_max = (mode == 1 || mode == 3) ? 0 : 14;
        out_stall_max = (mode == 1 || mode == 2) ? 0 : 14;
      end
      send_triangle(rand_triangle(), 1'b0, '0);
    end
    wait_drained();
  endtask

  function automatic directed_row_t mk_row(
      input logic s,
      input logic signed [15:0] ax, input logic signed [15:0] ay, input logic signed [15:0] az,
      input logic signed [15:0] bx, input logic signed [15:0] by, input logic signed [15:0] bz,
      input logic signed [15:0] cx, input logic signed [15:0] cy, input logic signed [15:0] cz,
      input logic [47:0] nrm, input logic typed, input logic signed [61:0] vol,
      input logic ovf);
    directed_row_t r;
    r.item.start_new_mesh = s;
    r.item.ax = ax; r.item.ay = ay; r.item.az = az;
    r.item.bx = bx; r.item.by = by; r.item.bz = bz;
    r.item.cx = cx; r.item.cy = cy; r.item.cz = cz;
    r.item.normal = nrm;
    r.typed = typed;
    r.want.volume = vol;
    r.want.ovf = ovf;
    return r;
  endfunction

  // Result side: random stalls, sometimes holding ready low until a result shows.
  initial begin : result_monitor
    volume_result_t want;
    int stall;
    bit hold_for_valid;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      hold_for_valid = 1'($urandom_range(0, 1));
      if (hold_for_valid) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
      end
      repeat (stall) @(posedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      results_seen++;
      if (pending_volumes.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = pending_volumes.pop_front();
        if (mesh_volume !== want.volume) begin
          report_mismatch($sformatf("mesh_volume %0d, expected %0d", mesh_volume,
                                    want.volume));
        end
        if (overflowed !== want.ovf) begin
          report_mismatch($sformatf("overflowed %0b, expected %0b", overflowed, want.ovf));
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_MATRIX_ROW0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    start_new_mesh <= 1'b0;
    vertex_a_x <= '0; vertex_a_y <= '0; vertex_a_z <= '0;
    vertex_b_x <= '0; vertex_b_y <= '0; vertex_b_z <= '0;
    vertex_c_x <= '0; vertex_c_y <= '0; vertex_c_z <= '0;
    face_normal <= '0;
    mat_row[0] = MATRIX_ROW0_RESET;
    mat_row[1] = MATRIX_ROW1_RESET;
    mat_row[2] = MATRIX_ROW2_RESET;
    det_sum = 0;
    sum_sat = 1'b0;

    // Unit cube corner triangle has determinant 2^24 in Q24.
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, N_ZERO, 1, 0, 0));
    directed_rows.push_back(mk_row(0, VUNIT, 0, 0, 0, VUNIT, 0, 0, 0, VUNIT, N_POS,
                                   1, 62'sd2796202, 0));
    directed_rows.push_back(mk_row(0, VUNIT, 0, 0, 0, VUNIT, 0, 0, 0, VUNIT, N_NEG,
                                   1, 0, 0));
    directed_rows.push_back(mk_row(0, VUNIT, 0, 0, 0, VUNIT, 0, 0, 0, VUNIT, N_NEG,
                                   1, -62'sd2796202, 0));
    // Zero normal counts as positive even for a reversed winding.
    directed_rows.push_back(mk_row(1, 0, VUNIT, 0, VUNIT, 0, 0, 0, 0, VUNIT, N_ZERO,
                                   1, 62'sd2796202, 0));
    // Vertex sum of zero: the triangle is flat and nothing is added.
    directed_rows.push_back(mk_row(0, VUNIT, 0, 0, 0, VUNIT, 0, -VUNIT, -VUNIT, 0, N_NEG,
                                   1, 62'sd2796202, 0));
    directed_rows.push_back(mk_row(1, VLO, VLO, VLO, VLO, VLO, VLO, VLO, VLO, VLO, N_MIN,
                                   1, 0, 0));
    directed_rows.push_back(mk_row(0, VHI, VHI, VHI, VHI, VHI, VHI, VHI, VHI, VHI, N_MAX,
                                   1, 0, 0));
    directed_rows.push_back(mk_row(1, VLO, VLO, VLO, VLO, VHI, VLO, VLO, VLO, VHI, N_XNEG,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(0, VLO, VLO, VLO, VLO, VHI, VLO, VLO, VLO, VHI, N_XPOS,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(0, VLO, VLO, VLO, VLO, VHI, VLO, VLO, VLO, VHI, N_XPOS,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(0, VHI, VLO, 0, 0, VHI, VLO, VLO, 0, VHI, N_MAX,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(0, 384, -384, 64, -1000, 2000, -3000, 12345, -23456, 777,
                                   48'h1234_8765_4321, 0, 0, 0));
    // Smallest determinant: sixths truncate toward zero on both sides.
    directed_rows.push_back(mk_row(1, 1, 0, 0, 0, 1, 0, 0, 0, 1, N_POS, 1, 0, 0));
    directed_rows.push_back(mk_row(0, 1, 0, 0, 0, 1, 0, 0, 0, 1, N_NEG, 1, 0, 0));
    directed_rows.push_back(mk_row(0, 1, 0, 0, 0, 1, 0, 0, 0, 1, N_NEG, 1, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_triangle(row.item, row.typed, row.want);
    end
    wait_drained();

    // A write to the unused index must leave the identity matrix in place.
    write_reg(REG_UNUSED, 48'(({$urandom, $urandom})));
    run_random(120);

    repeat (5) begin
      load_matrix(rand_matrix_row(), rand_matrix_row(), rand_matrix_row());
      run_random(120);
    end

    load_matrix(N_MIN, N_MIN, N_MIN);
    run_random(60);
    load_matrix(N_MAX, N_MAX, N_MAX);
    run_random(60);
    load_matrix(N_ZERO, N_ZERO, N_ZERO);
    run_random(60);
    load_matrix(MATRIX_ROW0_RESET, MATRIX_ROW1_RESET, MATRIX_ROW2_RESET);
    run_random(60);

    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_volumes.size() != 0) begin
      void'(pending_volumes.pop_front());
      report_mismatch("expected result never arrived");
    end

    if (mismatch_count == 0) begin
      $display("PASS mesh_signed_volume_accumulator");
    end else begin
      $display("FAIL mesh_signed_volume_accumulator");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/msva_pkg.sv
rtl/msva_datapath.sv
rtl/mesh_signed_volume_accumulator.sv
rtl/msva_checker.sv
test/tb_top.sv
